/* src/cpcr_pkg.sv */
// shared types, constants and helpers for the circle pair collision response block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cpcr_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int NORM_BITS  = 28;
  localparam int RATIO_BITS = 31;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;
  localparam int DLY_DEPTH  = 32;

  localparam logic [31:0] NEAR_EPS = 32'((64'd1 << FRAC_BITS) / 64'd10000);
  localparam logic [32:0] Q_MAX    = {33{1'b1}};
  localparam logic [16:0] REST_RST = 17'd32768;
  localparam logic [17:0] REST_ONE = 18'd65536;

  typedef struct packed {
    logic [31:0] first_pos_x;
    logic [31:0] first_pos_y;
    logic [31:0] first_vel_x;
    logic [31:0] first_vel_y;
    logic [30:0] first_radius;
    logic [31:0] first_mass;
    logic [31:0] second_pos_x;
    logic [31:0] second_pos_y;
    logic [31:0] second_vel_x;
    logic [31:0] second_vel_y;
    logic [30:0] second_radius;
    logic [31:0] second_mass;
  } pair_t;

  typedef struct packed {
    pair_t       pair;
    logic [31:0] md;
    logic [32:0] total;
    logic        touch;
    logic        neg_x;
    logic        neg_y;
    logic        near;
    logic [31:0] adx;
    logic [31:0] ady;
    logic [31:0] pen;
  } side_t;

  typedef struct packed {
    logic        touching;
    logic        impulse_applied;
    logic [31:0] new_first_pos_x;
    logic [31:0] new_first_pos_y;
    logic [31:0] new_first_vel_x;
    logic [31:0] new_first_vel_y;
    logic [31:0] new_second_pos_x;
    logic [31:0] new_second_pos_y;
    logic [31:0] new_second_vel_x;
    logic [31:0] new_second_vel_y;
  } res_t;

  // round to nearest on a magnitude, dropping the normal fraction bits
  function automatic logic [35:0] rnd_norm(input logic [63:0] m);
    logic [63:0] s;
    s = m + (64'd1 << (NORM_BITS - 1));
    return 36'(s >> NORM_BITS);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [37:0] v);
    logic [31:0] r;
    if (v > 38'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -38'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/circle_pair_collision_response.sv */
// top level of the circle pair collision response pipeline
// depends on cpcr_pkg, cpcr_isqrt, cpcr_div, cpcr_dly
//
// usage:
//   s_axis carries one circle pair per request, m_axis one resolved pair per request.
//   cfg_we_i / cfg_wdata_i write the restitution register (Q1.16); the user must write
//   it only while idle, the block itself does not enforce it. one request can be
//   accepted every cycle while s_axis_tready_o is high; most of the pipeline depth
//   lies in the 32-stage square root and 32-stage dividers, one bit per stage each.
//   the output register is backed by a skid register: while a result waits and the
//   receiver stalls, one more result lands in the skid register, then s_axis_tready_o
//   drops and the whole pipeline holds until the receiver takes the waiting result.
//   reset empties the pipeline and sets restitution to one half.
//   overlapping pairs are pushed apart along the contact normal, pairs that are not
//   separating also get a restitution impulse; all results saturate to 32-bit signed.
//   m_axis_tuser_o bit 0 flags touching, bit 1 flags an applied impulse.
`timescale 1ns / 1ps
`default_nettype none
module circle_pair_collision_response import cpcr_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [16:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // first pos_x, pos_y, vel_x, vel_y, radius, mass, then second the same, 2 zero bits
  input  wire logic [383:0] s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // new first pos_x, pos_y, vel_x, vel_y, then new second pos_x, pos_y, vel_x, vel_y
  output logic      [255:0] m_axis_tdata_o,
  // touching, impulse_applied
  output logic      [1:0]   m_axis_tuser_o
);

  logic        en;
  logic [16:0] rest_q;
  pair_t       in_pair;

  logic        s1_vld_q;
  pair_t       s1_pair_q;
  logic [32:0] s1_dx_q, s1_dy_q;
  logic [31:0] s1_md_q;
  logic [32:0] s1_total_q;

  logic        s2_vld_q;
  side_t       s2_side_q;
  logic        s2_far_q;
  side_t       s2_side_d;
  logic        s2_far_d;

  logic        s3_vld_q;
  side_t       s3_side_q;
  logic        s3_far_q;
  logic [63:0] s3_dx2_q, s3_dy2_q, s3_md2_q;

  logic        s4_vld_q;
  side_t       s4_side_q;
  logic [63:0] s4_rad_q;
  side_t       s4_side_d;
  logic [64:0] s4_sum;

  logic [31:0] sq_root;
  logic        sq_vld;
  side_t       sq_side;

  logic        s5_vld_q;
  side_t       s5_side_q;
  logic [31:0] s5_dist_q;
  side_t       s5_side_d;

  logic        s6_vld_q;
  side_t       s6_side_q;
  logic [31:0] s6_dist_q;
  logic [63:0] s6_pa_q, s6_pb_q;

  logic [31:0] dv_qx, dv_qy, dv_sa, dv_sb, dv_ra, dv_rb;
  logic        dv_vld;
  side_t       dv_side;

  logic               s7_vld_q;
  side_t              s7_side_q;
  logic [28:0]        s7_nxm_q, s7_nym_q;
  logic               s7_nxs_q, s7_nys_q;
  logic signed [29:0] s7_nx_q, s7_ny_q;
  logic [31:0]        s7_sa_q, s7_sb_q, s7_ra_q, s7_rb_q;
  logic signed [32:0] s7_rvx_q, s7_rvy_q;
  logic [28:0]        s7_nxm_d, s7_nym_d;
  logic               s7_nxs_d, s7_nys_d;

  logic               s8_vld_q;
  side_t              s8_side_q;
  logic [28:0]        s8_nxm_q, s8_nym_q;
  logic               s8_nxs_q, s8_nys_q;
  logic [31:0]        s8_ra_q, s8_rb_q;
  logic [63:0]        s8_pxa_q, s8_pya_q, s8_pxb_q, s8_pyb_q;
  logic signed [62:0] s8_tvx_q, s8_tvy_q;

  logic               s9_vld_q;
  res_t               s9_res_q;
  logic [28:0]        s9_nxm_q, s9_nym_q;
  logic               s9_nxs_q, s9_nys_q;
  logic [31:0]        s9_ra_q, s9_rb_q;
  logic signed [63:0] s9_sum_q;
  res_t               s9_res_d;
  logic signed [63:0] s9_sum_d;

  logic        s10_vld_q;
  res_t        s10_res_q;
  logic [28:0] s10_nxm_q, s10_nym_q;
  logic        s10_nxs_q, s10_nys_q;
  logic [31:0] s10_ra_q, s10_rb_q;
  logic [35:0] s10_avn_q;
  logic [63:0] s10_abs;

  logic        s11_vld_q;
  res_t        s11_res_q;
  logic [28:0] s11_nxm_q, s11_nym_q;
  logic        s11_nxs_q, s11_nys_q;
  logic [31:0] s11_ra_q, s11_rb_q;
  logic [53:0] s11_g_q;

  logic        s12_vld_q;
  res_t        s12_res_q;
  logic [28:0] s12_nxm_q, s12_nym_q;
  logic        s12_nxs_q, s12_nys_q;
  logic [31:0] s12_ra_q, s12_rb_q;
  logic [32:0] s12_q_q;
  logic [53:0] s12_rq;

  logic        s13_vld_q;
  res_t        s13_res_q;
  logic [28:0] s13_nxm_q, s13_nym_q;
  logic        s13_nxs_q, s13_nys_q;
  logic [64:0] s13_qa_q, s13_qb_q;

  logic        s14_vld_q;
  res_t        s14_res_q;
  logic [28:0] s14_nxm_q, s14_nym_q;
  logic        s14_nxs_q, s14_nys_q;
  logic [34:0] s14_dva_q, s14_dvb_q;
  logic [65:0] s14_ra, s14_rb;

  logic        s15_vld_q;
  res_t        s15_res_q;
  logic        s15_nxs_q, s15_nys_q;
  logic [63:0] s15_vxa_q, s15_vya_q, s15_vxb_q, s15_vyb_q;

  logic        s16_vld_q;
  res_t        s16_res_q;
  res_t        s16_res_d;

  logic        out_vld_q, skid_vld_q;
  res_t        out_res_q, skid_res_q;

  assign en              = !skid_vld_q;
  assign s_axis_tready_o = en;

  assign in_pair.first_pos_x   = s_axis_tdata_i[31:0];
  assign in_pair.first_pos_y   = s_axis_tdata_i[63:32];
  assign in_pair.first_vel_x   = s_axis_tdata_i[95:64];
  assign in_pair.first_vel_y   = s_axis_tdata_i[127:96];
  assign in_pair.first_radius  = s_axis_tdata_i[158:128];
  assign in_pair.first_mass    = s_axis_tdata_i[190:159];
  assign in_pair.second_pos_x  = s_axis_tdata_i[222:191];
  assign in_pair.second_pos_y  = s_axis_tdata_i[254:223];
  assign in_pair.second_vel_x  = s_axis_tdata_i[286:255];
  assign in_pair.second_vel_y  = s_axis_tdata_i[318:287];
  assign in_pair.second_radius = s_axis_tdata_i[349:319];
  assign in_pair.second_mass   = s_axis_tdata_i[381:350];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q <= REST_RST;
    end else if (cfg_we_i) begin
      rest_q <= cfg_wdata_i;
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      s10_vld_q <= 1'b0;
      s11_vld_q <= 1'b0;
      s12_vld_q <= 1'b0;
      s13_vld_q <= 1'b0;
      s14_vld_q <= 1'b0;
      s15_vld_q <= 1'b0;
      s16_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= s_axis_tvalid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= sq_vld;
      s6_vld_q  <= s5_vld_q;
      s7_vld_q  <= dv_vld;
      s8_vld_q  <= s7_vld_q;
      s9_vld_q  <= s8_vld_q;
      s10_vld_q <= s9_vld_q;
      s11_vld_q <= s10_vld_q;
      s12_vld_q <= s11_vld_q;
      s13_vld_q <= s12_vld_q;
      s14_vld_q <= s13_vld_q;
      s15_vld_q <= s14_vld_q;
      s16_vld_q <= s15_vld_q;
    end
  end

  // front: differences, overlap test
  always_comb begin
    logic [32:0] adx, ady;
    adx = s1_dx_q[32] ? 33'(33'd0 - s1_dx_q) : s1_dx_q;
    ady = s1_dy_q[32] ? 33'(33'd0 - s1_dy_q) : s1_dy_q;
    s2_far_d        = (adx >= {1'b0, s1_md_q}) || (ady >= {1'b0, s1_md_q});
    s2_side_d       = '0;
    s2_side_d.pair  = s1_pair_q;
    s2_side_d.md    = s1_md_q;
    s2_side_d.total = s1_total_q;
    s2_side_d.neg_x = s1_dx_q[32];
    s2_side_d.neg_y = s1_dy_q[32];
    s2_side_d.adx   = adx[31:0];
    s2_side_d.ady   = ady[31:0];
  end

  assign s4_sum = {1'b0, s3_dx2_q} + {1'b0, s3_dy2_q};

  always_comb begin
    s4_side_d       = s3_side_q;
    s4_side_d.touch = !s3_far_q && (s4_sum < {1'b0, s3_md2_q}) && (s3_side_q.total != 33'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pair_q  <= in_pair;
      s1_dx_q    <= 33'({in_pair.second_pos_x[31], in_pair.second_pos_x}
                      - {in_pair.first_pos_x[31], in_pair.first_pos_x});
      s1_dy_q    <= 33'({in_pair.second_pos_y[31], in_pair.second_pos_y}
                      - {in_pair.first_pos_y[31], in_pair.first_pos_y});
      s1_md_q    <= {1'b0, in_pair.first_radius} + {1'b0, in_pair.second_radius};
      s1_total_q <= {1'b0, in_pair.first_mass} + {1'b0, in_pair.second_mass};

      s2_side_q <= s2_side_d;
      s2_far_q  <= s2_far_d;

      s3_side_q <= s2_side_q;
      s3_far_q  <= s2_far_q;
      s3_dx2_q  <= {32'd0, s2_side_q.adx} * {32'd0, s2_side_q.adx};
      s3_dy2_q  <= {32'd0, s2_side_q.ady} * {32'd0, s2_side_q.ady};
      s3_md2_q  <= {32'd0, s2_side_q.md} * {32'd0, s2_side_q.md};

      s4_side_q <= s4_side_d;
      s4_rad_q  <= s4_sum[63:0];
    end
  end

  cpcr_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (s4_rad_q),
    .root_o (sq_root)
  );

  cpcr_dly u_dly_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s4_vld_q),
    .side_i (s4_side_q),
    .vld_o  (sq_vld),
    .side_o (sq_side)
  );

  // penetration depth
  always_comb begin
    s5_side_d      = sq_side;
    s5_side_d.near = (sq_root <= NEAR_EPS);
    s5_side_d.pen  = s5_side_d.near ? sq_side.md : 32'(sq_side.md - sq_root);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_side_q <= s5_side_d;
      s5_dist_q <= sq_root;
      s6_side_q <= s5_side_q;
      s6_dist_q <= s5_dist_q;
      s6_pa_q   <= {32'd0, s5_side_q.pen} * {32'd0, s5_side_q.pair.second_mass};
      s6_pb_q   <= {32'd0, s5_side_q.pen} * {32'd0, s5_side_q.pair.first_mass};
    end
  end

  cpcr_div u_div_nx (
    .clk_i (clk_i), .en_i (en),
    .num_i ({4'd0, s6_side_q.adx, 28'd0}), .den_i ({1'b0, s6_dist_q}), .quo_o (dv_qx)
  );
  cpcr_div u_div_ny (
    .clk_i (clk_i), .en_i (en),
    .num_i ({4'd0, s6_side_q.ady, 28'd0}), .den_i ({1'b0, s6_dist_q}), .quo_o (dv_qy)
  );
  cpcr_div u_div_sa (
    .clk_i (clk_i), .en_i (en),
    .num_i (s6_pa_q), .den_i (s6_side_q.total), .quo_o (dv_sa)
  );
  cpcr_div u_div_sb (
    .clk_i (clk_i), .en_i (en),
    .num_i (s6_pb_q), .den_i (s6_side_q.total), .quo_o (dv_sb)
  );
  cpcr_div u_div_ra (
    .clk_i (clk_i), .en_i (en),
    .num_i ({1'b0, s6_side_q.pair.second_mass, 31'd0}), .den_i (s6_side_q.total),
    .quo_o (dv_ra)
  );
  cpcr_div u_div_rb (
    .clk_i (clk_i), .en_i (en),
    .num_i ({1'b0, s6_side_q.pair.first_mass, 31'd0}), .den_i (s6_side_q.total),
    .quo_o (dv_rb)
  );

  cpcr_dly u_dly_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s6_vld_q),
    .side_i (s6_side_q),
    .vld_o  (dv_vld),
    .side_o (dv_side)
  );

  // contact normal
  always_comb begin
    s7_nxm_d = dv_side.near ? 29'(64'd1 << NORM_BITS) : dv_qx[28:0];
    s7_nym_d = dv_side.near ? 29'd0 : dv_qy[28:0];
    s7_nxs_d = !dv_side.near && dv_side.neg_x;
    s7_nys_d = !dv_side.near && dv_side.neg_y;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_side_q <= dv_side;
      s7_nxm_q  <= s7_nxm_d;
      s7_nym_q  <= s7_nym_d;
      s7_nxs_q  <= s7_nxs_d;
      s7_nys_q  <= s7_nys_d;
      s7_nx_q   <= s7_nxs_d ? 30'(30'd0 - {1'b0, s7_nxm_d}) : {1'b0, s7_nxm_d};
      s7_ny_q   <= s7_nys_d ? 30'(30'd0 - {1'b0, s7_nym_d}) : {1'b0, s7_nym_d};
      s7_sa_q   <= dv_sa;
      s7_sb_q   <= dv_sb;
      s7_ra_q   <= dv_ra;
      s7_rb_q   <= dv_rb;
      s7_rvx_q  <= 33'({dv_side.pair.second_vel_x[31], dv_side.pair.second_vel_x}
                     - {dv_side.pair.first_vel_x[31], dv_side.pair.first_vel_x});
      s7_rvy_q  <= 33'({dv_side.pair.second_vel_y[31], dv_side.pair.second_vel_y}
                     - {dv_side.pair.first_vel_y[31], dv_side.pair.first_vel_y});

      s8_side_q <= s7_side_q;
      s8_nxm_q  <= s7_nxm_q;
      s8_nym_q  <= s7_nym_q;
      s8_nxs_q  <= s7_nxs_q;
      s8_nys_q  <= s7_nys_q;
      s8_ra_q   <= s7_ra_q;
      s8_rb_q   <= s7_rb_q;
      s8_pxa_q  <= {35'd0, s7_nxm_q} * {32'd0, s7_sa_q};
      s8_pya_q  <= {35'd0, s7_nym_q} * {32'd0, s7_sa_q};
      s8_pxb_q  <= {35'd0, s7_nxm_q} * {32'd0, s7_sb_q};
      s8_pyb_q  <= {35'd0, s7_nym_q} * {32'd0, s7_sb_q};
      s8_tvx_q  <= s7_rvx_q * s7_nx_q;
      s8_tvy_q  <= s7_rvy_q * s7_ny_q;
    end
  end

  // position correction and relative normal speed
  always_comb begin
    logic [35:0]        oxa, oya, oxb, oyb;
    logic signed [37:0] ax, ay, bx, by;
    pair_t              p;
    p   = s8_side_q.pair;
    oxa = rnd_norm(s8_pxa_q);
    oya = rnd_norm(s8_pya_q);
    oxb = rnd_norm(s8_pxb_q);
    oyb = rnd_norm(s8_pyb_q);
    ax  = s8_nxs_q ? 38'({{6{p.first_pos_x[31]}}, p.first_pos_x} + {2'b00, oxa})
                   : 38'({{6{p.first_pos_x[31]}}, p.first_pos_x} - {2'b00, oxa});
    ay  = s8_nys_q ? 38'({{6{p.first_pos_y[31]}}, p.first_pos_y} + {2'b00, oya})
                   : 38'({{6{p.first_pos_y[31]}}, p.first_pos_y} - {2'b00, oya});
    bx  = s8_nxs_q ? 38'({{6{p.second_pos_x[31]}}, p.second_pos_x} - {2'b00, oxb})
                   : 38'({{6{p.second_pos_x[31]}}, p.second_pos_x} + {2'b00, oxb});
    by  = s8_nys_q ? 38'({{6{p.second_pos_y[31]}}, p.second_pos_y} - {2'b00, oyb})
                   : 38'({{6{p.second_pos_y[31]}}, p.second_pos_y} + {2'b00, oyb});
    s9_sum_d = 64'({s8_tvx_q[62], s8_tvx_q} + {s8_tvy_q[62], s8_tvy_q});
    s9_res_d.touching         = s8_side_q.touch;
    s9_res_d.impulse_applied  = s8_side_q.touch && !(s9_sum_d > 64'sd0);
    s9_res_d.new_first_pos_x  = s8_side_q.touch ? sat32(ax) : p.first_pos_x;
    s9_res_d.new_first_pos_y  = s8_side_q.touch ? sat32(ay) : p.first_pos_y;
    s9_res_d.new_first_vel_x  = p.first_vel_x;
    s9_res_d.new_first_vel_y  = p.first_vel_y;
    s9_res_d.new_second_pos_x = s8_side_q.touch ? sat32(bx) : p.second_pos_x;
    s9_res_d.new_second_pos_y = s8_side_q.touch ? sat32(by) : p.second_pos_y;
    s9_res_d.new_second_vel_x = p.second_vel_x;
    s9_res_d.new_second_vel_y = p.second_vel_y;
  end

  assign s10_abs = s9_sum_q[63] ? 64'(64'd0 - s9_sum_q) : s9_sum_q;
  assign s12_rq  = 54'(s11_g_q + 54'd32768);
  assign s14_ra  = {1'b0, s13_qa_q} + (66'd1 << (RATIO_BITS - 1));
  assign s14_rb  = {1'b0, s13_qb_q} + (66'd1 << (RATIO_BITS - 1));

  // impulse magnitude and shares
  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_res_q  <= s9_res_d;
      s9_sum_q  <= s9_sum_d;
      s9_nxm_q  <= s8_nxm_q;
      s9_nym_q  <= s8_nym_q;
      s9_nxs_q  <= s8_nxs_q;
      s9_nys_q  <= s8_nys_q;
      s9_ra_q   <= s8_ra_q;
      s9_rb_q   <= s8_rb_q;

      s10_res_q <= s9_res_q;
      s10_nxm_q <= s9_nxm_q;
      s10_nym_q <= s9_nym_q;
      s10_nxs_q <= s9_nxs_q;
      s10_nys_q <= s9_nys_q;
      s10_ra_q  <= s9_ra_q;
      s10_rb_q  <= s9_rb_q;
      s10_avn_q <= rnd_norm(s10_abs);

      s11_res_q <= s10_res_q;
      s11_nxm_q <= s10_nxm_q;
      s11_nym_q <= s10_nym_q;
      s11_nxs_q <= s10_nxs_q;
      s11_nys_q <= s10_nys_q;
      s11_ra_q  <= s10_ra_q;
      s11_rb_q  <= s10_rb_q;
      s11_g_q   <= {18'd0, s10_avn_q} * {36'd0, REST_ONE + {1'b0, rest_q}};

      s12_res_q <= s11_res_q;
      s12_nxm_q <= s11_nxm_q;
      s12_nym_q <= s11_nym_q;
      s12_nxs_q <= s11_nxs_q;
      s12_nys_q <= s11_nys_q;
      s12_ra_q  <= s11_ra_q;
      s12_rb_q  <= s11_rb_q;
      s12_q_q   <= (s12_rq[53:16] > {5'd0, Q_MAX}) ? Q_MAX : s12_rq[48:16];

      s13_res_q <= s12_res_q;
      s13_nxm_q <= s12_nxm_q;
      s13_nym_q <= s12_nym_q;
      s13_nxs_q <= s12_nxs_q;
      s13_nys_q <= s12_nys_q;
      s13_qa_q  <= {32'd0, s12_q_q} * {33'd0, s12_ra_q};
      s13_qb_q  <= {32'd0, s12_q_q} * {33'd0, s12_rb_q};

      s14_res_q <= s13_res_q;
      s14_nxm_q <= s13_nxm_q;
      s14_nym_q <= s13_nym_q;
      s14_nxs_q <= s13_nxs_q;
      s14_nys_q <= s13_nys_q;
      s14_dva_q <= s14_ra[65:31];
      s14_dvb_q <= s14_rb[65:31];

      s15_res_q <= s14_res_q;
      s15_nxs_q <= s14_nxs_q;
      s15_nys_q <= s14_nys_q;
      s15_vxa_q <= {29'd0, s14_dva_q} * {35'd0, s14_nxm_q};
      s15_vya_q <= {29'd0, s14_dva_q} * {35'd0, s14_nym_q};
      s15_vxb_q <= {29'd0, s14_dvb_q} * {35'd0, s14_nxm_q};
      s15_vyb_q <= {29'd0, s14_dvb_q} * {35'd0, s14_nym_q};

      s16_res_q <= s16_res_d;
    end
  end

  // velocity update
  always_comb begin
    logic [35:0]        oxa, oya, oxb, oyb;
    logic signed [37:0] ax, ay, bx, by;
    res_t               r;
    r   = s15_res_q;
    oxa = rnd_norm(s15_vxa_q);
    oya = rnd_norm(s15_vya_q);
    oxb = rnd_norm(s15_vxb_q);
    oyb = rnd_norm(s15_vyb_q);
    ax  = s15_nxs_q ? 38'({{6{r.new_first_vel_x[31]}}, r.new_first_vel_x} + {2'b00, oxa})
                    : 38'({{6{r.new_first_vel_x[31]}}, r.new_first_vel_x} - {2'b00, oxa});
    ay  = s15_nys_q ? 38'({{6{r.new_first_vel_y[31]}}, r.new_first_vel_y} + {2'b00, oya})
                    : 38'({{6{r.new_first_vel_y[31]}}, r.new_first_vel_y} - {2'b00, oya});
    bx  = s15_nxs_q ? 38'({{6{r.new_second_vel_x[31]}}, r.new_second_vel_x} - {2'b00, oxb})
                    : 38'({{6{r.new_second_vel_x[31]}}, r.new_second_vel_x} + {2'b00, oxb});
    by  = s15_nys_q ? 38'({{6{r.new_second_vel_y[31]}}, r.new_second_vel_y} - {2'b00, oyb})
                    : 38'({{6{r.new_second_vel_y[31]}}, r.new_second_vel_y} + {2'b00, oyb});
    s16_res_d = r;
    if (r.impulse_applied) begin
      s16_res_d.new_first_vel_x  = sat32(ax);
      s16_res_d.new_first_vel_y  = sat32(ay);
      s16_res_d.new_second_vel_x = sat32(bx);
      s16_res_d.new_second_vel_y = sat32(by);
    end
  end

  // output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (m_axis_tready_i) begin
        skid_vld_q <= 1'b0;
      end
    end else if (s16_vld_q) begin
      if (out_vld_q && !m_axis_tready_i) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (m_axis_tready_i) begin
        out_res_q <= skid_res_q;
      end
    end else if (s16_vld_q) begin
      if (out_vld_q && !m_axis_tready_i) begin
        skid_res_q <= s16_res_q;
      end else begin
        out_res_q <= s16_res_q;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = {out_res_q.impulse_applied, out_res_q.touching};
  assign m_axis_tdata_o  = {out_res_q.new_second_vel_y, out_res_q.new_second_vel_x,
                            out_res_q.new_second_pos_y, out_res_q.new_second_pos_x,
                            out_res_q.new_first_vel_y,  out_res_q.new_first_vel_x,
                            out_res_q.new_first_pos_y,  out_res_q.new_first_pos_x};

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> m_axis_tvalid_o)
    else $error("skid register holds a result while the output register is empty");

  a_impulse_touch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[1] && !m_axis_tuser_o[0]))
    else $error("impulse flagged on a pair that is not touching");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("skid register filled without a stalled output");

endmodule
`default_nettype wire

/* src/cpcr_isqrt.sv */
// pipelined integer square root, one result bit per stage
// depends on cpcr_pkg
`timescale 1ns / 1ps
`default_nettype none
module cpcr_isqrt import cpcr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [63:0] rad_i,
  output logic      [31:0] root_o
);

  logic [33:0] r_q [SQRT_STEPS];
  logic [31:0] q_q [SQRT_STEPS];
  logic [63:0] x_q [SQRT_STEPS];
  logic [33:0] r_p [SQRT_STEPS];
  logic [31:0] q_p [SQRT_STEPS];
  logic [63:0] x_p [SQRT_STEPS];
  logic [33:0] r_d [SQRT_STEPS];
  logic [31:0] q_d [SQRT_STEPS];
  logic [63:0] x_d [SQRT_STEPS];

  always_comb begin
    logic [35:0] trial;
    logic [35:0] tst;
    r_p[0] = '0;
    q_p[0] = '0;
    x_p[0] = rad_i;
    for (int k = 1; k < SQRT_STEPS; k++) begin
      r_p[k] = r_q[k-1];
      q_p[k] = q_q[k-1];
      x_p[k] = x_q[k-1];
    end
    for (int k = 0; k < SQRT_STEPS; k++) begin
      trial  = {r_p[k], x_p[k][63:62]};
      tst    = {2'b00, q_p[k], 2'b01};
      x_d[k] = {x_p[k][61:0], 2'b00};
      if (trial >= tst) begin
        r_d[k] = 34'(trial - tst);
        q_d[k] = {q_p[k][30:0], 1'b1};
      end else begin
        r_d[k] = trial[33:0];
        q_d[k] = {q_p[k][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
        r_q[k] <= r_d[k];
        q_q[k] <= q_d[k];
        x_q[k] <= x_d[k];
      end
    end
  end

  assign root_o = q_q[SQRT_STEPS-1];

endmodule
`default_nettype wire

/* src/cpcr_div.sv */
// pipelined restoring divider, 64-bit dividend by 33-bit divisor, one quotient bit per stage
// depends on cpcr_pkg
`timescale 1ns / 1ps
`default_nettype none
module cpcr_div import cpcr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [63:0] num_i,
  input  wire logic [32:0] den_i,
  output logic      [31:0] quo_o
);

  logic [32:0] rem_q [DIV_STEPS];
  logic [31:0] low_q [DIV_STEPS];
  logic [31:0] quo_q [DIV_STEPS];
  logic [32:0] den_q [DIV_STEPS];
  logic [32:0] rem_p [DIV_STEPS];
  logic [31:0] low_p [DIV_STEPS];
  logic [31:0] quo_p [DIV_STEPS];
  logic [32:0] den_p [DIV_STEPS];
  logic [32:0] rem_d [DIV_STEPS];
  logic [31:0] quo_d [DIV_STEPS];

  always_comb begin
    logic [33:0] trial;
    rem_p[0] = {1'b0, num_i[63:32]};
    low_p[0] = num_i[31:0];
    quo_p[0] = '0;
    den_p[0] = den_i;
    for (int k = 1; k < DIV_STEPS; k++) begin
      rem_p[k] = rem_q[k-1];
      low_p[k] = low_q[k-1];
      quo_p[k] = quo_q[k-1];
      den_p[k] = den_q[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {rem_p[k], low_p[k][31]};
      if (trial >= {1'b0, den_p[k]}) begin
        rem_d[k] = 33'(trial - {1'b0, den_p[k]});
        quo_d[k] = {quo_p[k][30:0], 1'b1};
      end else begin
        rem_d[k] = trial[32:0];
        quo_d[k] = {quo_p[k][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_q[k] <= rem_d[k];
        low_q[k] <= {low_p[k][30:0], 1'b0};
        quo_q[k] <= quo_d[k];
        den_q[k] <= den_p[k];
      end
    end
  end

  assign quo_o = quo_q[DIV_STEPS-1];

endmodule
`default_nettype wire

/* src/cpcr_dly.sv */
// side data delay line matching the square root and divider latency
// depends on cpcr_pkg
`timescale 1ns / 1ps
`default_nettype none
module cpcr_dly import cpcr_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire logic  vld_i,
  input  wire side_t side_i,
  output logic       vld_o,
  output side_t      side_o
);

  logic  vld_q  [DLY_DEPTH];
  side_t side_q [DLY_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DLY_DEPTH; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 1; k < DLY_DEPTH; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < DLY_DEPTH; k++) side_q[k] <= side_q[k-1];
    end
  end

  assign vld_o  = vld_q[DLY_DEPTH-1];
  assign side_o = side_q[DLY_DEPTH-1];

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// self-checking bench for circle_pair_collision_response: random and directed pairs
// depends on cpcr_pkg and the block's rtl; a scoreboard class predicts each result
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import cpcr_pkg::*;

  localparam int LATENCY   = 80;
  localparam int N_RANDOM  = 1200;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic        touching;
    logic        impulse;
    logic [31:0] v [8];
  } outcome_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [16:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [383:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [255:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  int  n_errors = 0;
  int  n_checked = 0;
  int  n_touch = 0;
  int  n_impulse = 0;
  int  idle_cycles = 0;
  bit  sink_idle_on = 1'b1;
  bit  sink_hold = 1'b0;
  bit  src_idle_on = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  circle_pair_collision_response i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    n_errors++;
  endtask

  function automatic longint signed mag_round(input longint signed v, input int s);
    longint unsigned m;
    longint unsigned r;
    m = (v < 0) ? longint'(-v) : longint'(v);
    r = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [31:0] clamp32(input longint signed v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint unsigned root64(input longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  class collision_board;
    logic [16:0] restitution;
    outcome_t    pending [$];

    function new();
      restitution = REST_RST;
    endfunction

    function outcome_t resolve(input pair_t p);
      outcome_t o;
      longint signed ax, ay, avx, avy, bx, by, bvx, bvy, dx, dy, nx, ny, sa, sb, sum, dva, dvb;
      longint unsigned ra, rb, ma, mb, adx, ady, md, dx2, dy2, md2, total, span, pen;
      longint unsigned avn, q, rat_a, rat_b;
      ax = longint'(signed'(p.first_pos_x));   ay = longint'(signed'(p.first_pos_y));
      avx = longint'(signed'(p.first_vel_x));  avy = longint'(signed'(p.first_vel_y));
      bx = longint'(signed'(p.second_pos_x));  by = longint'(signed'(p.second_pos_y));
      bvx = longint'(signed'(p.second_vel_x)); bvy = longint'(signed'(p.second_vel_y));
      ra = p.first_radius;  rb = p.second_radius;
      ma = p.first_mass;    mb = p.second_mass;
      o.touching = 1'b0;
      o.impulse = 1'b0;
      o.v[0] = p.first_pos_x;  o.v[1] = p.first_pos_y;
      o.v[2] = p.first_vel_x;  o.v[3] = p.first_vel_y;
      o.v[4] = p.second_pos_x; o.v[5] = p.second_pos_y;
      o.v[6] = p.second_vel_x; o.v[7] = p.second_vel_y;
      dx = bx - ax;
      dy = by - ay;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      md = ra + rb;
      if (adx >= md || ady >= md) return o;
      dx2 = adx * adx; dy2 = ady * ady; md2 = md * md;
      if (dx2 >= md2 - dy2) return o;
      total = ma + mb;
      if (total == 0) return o;
      span = root64(dx2 + dy2);
      if (span > NEAR_EPS) begin
        nx = longint'((adx << NORM_BITS) / span);
        ny = longint'((ady << NORM_BITS) / span);
        if (dx < 0) nx = -nx;
        if (dy < 0) ny = -ny;
        pen = md - span;
      end else begin
        nx = 64'sd1 <<< NORM_BITS;
        ny = 0;
        pen = md;
      end
      sa = longint'((pen * mb) / total);
      sb = longint'((pen * ma) / total);
      o.touching = 1'b1;
      o.v[0] = clamp32(ax - mag_round(nx * sa, NORM_BITS));
      o.v[1] = clamp32(ay - mag_round(ny * sa, NORM_BITS));
      o.v[4] = clamp32(bx + mag_round(nx * sb, NORM_BITS));
      o.v[5] = clamp32(by + mag_round(ny * sb, NORM_BITS));
      sum = (bvx - avx) * nx + (bvy - avy) * ny;
      if (sum > 0) return o;
      o.impulse = 1'b1;
      avn = -mag_round(sum, NORM_BITS);
      q = (avn * (64'd65536 + restitution) + 64'd32768) >> 16;
      if (q > Q_MAX) q = Q_MAX;
      rat_a = (mb << RATIO_BITS) / total;
      rat_b = (ma << RATIO_BITS) / total;
      dva = longint'((q * rat_a + (64'd1 << (RATIO_BITS - 1))) >> RATIO_BITS);
      dvb = longint'((q * rat_b + (64'd1 << (RATIO_BITS - 1))) >> RATIO_BITS);
      o.v[2] = clamp32(avx - mag_round(dva * nx, NORM_BITS));
      o.v[3] = clamp32(avy - mag_round(dva * ny, NORM_BITS));
      o.v[6] = clamp32(bvx + mag_round(dvb * nx, NORM_BITS));
      o.v[7] = clamp32(bvy + mag_round(dvb * ny, NORM_BITS));
      return o;
    endfunction

    function void note_request(input pair_t p);
      pending.insert(pending.size(), resolve(p));
    endfunction

    task check_result(input logic [255:0] data, input logic [1:0] flags);
      outcome_t e;
      if (pending.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (e.touching) n_touch++;
      if (e.impulse) n_impulse++;
      if (flags[0] !== e.touching)
        report($sformatf("touching got %b exp %b", flags[0], e.touching));
      if (flags[1] !== e.impulse)
        report($sformatf("impulse_applied got %b exp %b", flags[1], e.impulse));
      for (int k = 0; k < 8; k++) begin
        if (data[32*k +: 32] !== e.v[k])
          report($sformatf("word %0d got %h exp %h", k, data[32*k +: 32], e.v[k]));
      end
    endtask
  endclass

  collision_board board = new();

  function automatic logic [383:0] pack_pair(input pair_t p);
    return {2'b00, p.second_mass, p.second_radius, p.second_vel_y, p.second_vel_x,
            p.second_pos_y, p.second_pos_x, p.first_mass, p.first_radius,
            p.first_vel_y, p.first_vel_x, p.first_pos_y, p.first_pos_x};
  endfunction

  function automatic logic [31:0] rand_small();
    return 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
  endfunction

  // mostly overlapping pairs of moderate size, with some wide and raw noise
  function automatic pair_t make_pair();
    pair_t p;
    int kind;
    kind = $urandom_range(0, 9);
    p.first_pos_x = rand_small();  p.first_pos_y = rand_small();
    p.first_vel_x = rand_small();  p.first_vel_y = rand_small();
    p.second_vel_x = rand_small(); p.second_vel_y = rand_small();
    p.first_radius = 31'($urandom_range(0, 4 << 16));
    p.second_radius = 31'($urandom_range(0, 4 << 16));
    p.second_pos_x = p.first_pos_x + 32'($urandom_range(0, 6 << 16)) - (3 << 16);
    p.second_pos_y = p.first_pos_y + 32'($urandom_range(0, 6 << 16)) - (3 << 16);
    p.first_mass = $urandom_range(1, 16 << 16);
    p.second_mass = $urandom_range(1, 16 << 16);
    if (kind == 0) begin
      p = pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    end else if (kind == 1) begin
      p.first_pos_x = $urandom; p.first_vel_x = $urandom; p.first_vel_y = $urandom;
      p.second_vel_x = $urandom; p.second_vel_y = $urandom;
      p.first_radius = 31'($urandom); p.second_radius = 31'($urandom);
      p.second_pos_x = p.first_pos_x + ($urandom >> $urandom_range(1, 31));
      p.first_mass = $urandom; p.second_mass = $urandom;
    end else if (kind == 2) begin
      p.second_pos_x = p.first_pos_x + $urandom_range(0, 12) - 6;
      p.second_pos_y = p.first_pos_y + $urandom_range(0, 12) - 6;
    end else if (kind == 3) begin
      if ($urandom_range(0, 1)) p.first_mass = 0; else p.second_mass = 0;
      if ($urandom_range(0, 3) == 0) begin
        p.first_mass = 0;
        p.second_mass = 0;
      end
    end
    return p;
  endfunction

  task automatic send_pair(input pair_t p);
    while (src_idle_on && $urandom_range(0, 99) < 35) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata_i <= pack_pair(p);
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_request(p);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_restitution(input logic [16:0] val);
    cfg_wdata_i <= val;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    board.restitution = val;
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_directed();
    pair_t b, p;
    b = '0;
    b.first_radius = 31'(2 << 16);  b.second_radius = 31'(2 << 16);
    b.first_mass = 32'(1 << 16);    b.second_mass = 32'(3 << 16);
    b.second_pos_x = 32'(1 << 16);  b.first_vel_x = 32'(1 << 16);
    send_pair(b);                         // head-on overlap
    p = b; p.second_pos_x = 0; send_pair(p);         // coincident centres
    p = b; p.second_pos_x = 3; send_pair(p);         // nearly coincident
    p = b; p.first_mass = 0; send_pair(p);
    p = b; p.second_mass = 0; send_pair(p);
    p = b; p.first_mass = 0; p.second_mass = 0; send_pair(p);
    p = b; p.first_radius = 0; p.second_radius = 0; send_pair(p);
    p = b; p.first_vel_x = 32'hFFFF_0000; send_pair(p);  // separating
    p = b; p.second_pos_x = 32'(4 << 16); send_pair(p);  // just apart
    p = b; p.first_pos_x = 32'h8000_0000; p.second_pos_x = 32'h7FFF_FFFF; send_pair(p);
    p = b; p.first_radius = '1; p.second_radius = '1; p.second_pos_y = 32'h7FFF_FFFF;
    p.first_pos_y = 32'h8000_0000; p.first_mass = '1; p.second_mass = '1; send_pair(p);
    p = b; p.first_radius = '1; p.second_radius = '1;
    p.first_vel_x = 32'h7FFF_FFFF; p.second_vel_x = 32'h8000_0000;
    p.first_vel_y = 32'h8000_0000; p.second_vel_y = 32'h7FFF_FFFF;
    p.second_pos_y = 32'hFFFF_0000; send_pair(p);
    p = b; p.first_mass = 1; p.second_mass = '1; send_pair(p);
    p = b; p.first_pos_x = 32'h7FFF_FFFF; p.first_pos_y = 32'h7FFF_FFFF;
    p.second_pos_x = 32'h7FFF_0000; p.second_pos_y = 32'h7FFF_0000; send_pair(p);
  endtask

  initial begin : stimulus
    logic [16:0] rest_values [5];
    rest_values = '{17'd0, 17'd65536, 17'h1FFFF, 17'd12345, 17'd32768};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      write_restitution(rest_values[ph]);
      if (ph == 0) run_directed();
      for (int n = 0; n < N_RANDOM / 5; n++) begin
        if (ph == 2 && n == 40) begin
          sink_hold = 1'b1;
          sink_idle_on = 1'b0;
        end
        if (ph == 3) src_idle_on = (n >= 120);
        send_pair(make_pair());
      end
      drain();
      sink_idle_on = 1'b1;
    end
    $display("checked %0d pairs: %0d touching, %0d with impulse", n_checked, n_touch,
             n_impulse);
    $display("restitution swept over zero, one, max and mid values; backpressure applied");
    if (n_errors == 0) begin
      $display("** circle_pair_collision_response: PASSED **");
    end else begin
      $display("** circle_pair_collision_response: FAILED **");
    end
    $finish;
  end

  // long receiver hold-off so the pipeline fills and backs up
  initial begin : hold_off
    wait (sink_hold);
    repeat (300) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) board.check_result(m_axis_tdata_o, m_axis_tuser_o);
    m_axis_tready_i <= !sink_hold && !(sink_idle_on && $urandom_range(0, 99) < 35);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", idle_cycles);
      $display("** circle_pair_collision_response: FAILED **");
      $finish;
    end
  end

endmodule
`default_nettype wire

/* files.f */
src/cpcr_pkg.sv
src/cpcr_isqrt.sv
src/cpcr_div.sv
src/cpcr_dly.sv
src/circle_pair_collision_response.sv
tb/tb_top.sv
